FILE: design/lasc_pkg.sv
package lasc_pkg;

   localparam int MAX_LEN  = 256;
   localparam int IDX_W    = $clog2(MAX_LEN);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int SYM_W    = 8;
   localparam int OP_W     = 2;
   localparam int SCORE_W  = 10;
   localparam int SUM_W    = SCORE_W + 2;
   localparam int THR_W    = 12;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = THR_W + LEN_W + 1;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam int MATCH_SCORE    = 3;
   localparam int MISMATCH_SCORE = -3;
   localparam int GAP_PENALTY    = 2;

   localparam logic REG_THRESHOLD = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_COMPUTE       = 2'd2,
      OP_NONE          = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_CELL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             row_start;
      logic             cell_en;
      logic             first_row;
      logic [IDX_W-1:0] rd_col;
      logic [IDX_W-1:0] wr_col;
   } cell_ctrl_type;

endpackage

FILE: design/lasc_cell_core.sv
module lasc_cell_core (
   input  logic                           clock,
   input  lasc_pkg::cell_ctrl_type        ctrl,
   input  logic                           sym_match,
   output logic [lasc_pkg::SCORE_W-1:0]   best_score
);
   import lasc_pkg::*;

   logic [SCORE_W-1:0] row_mem [MAX_LEN];
   logic [SCORE_W-1:0] up_rd_ff;
   logic [SCORE_W-1:0] diag_ff, diag_in;
   logic [SCORE_W-1:0] left_ff, left_in;
   logic [SCORE_W-1:0] best_ff, best_in;

   logic [SCORE_W-1:0]      up;
   logic [SCORE_W-1:0]      cell_score;
   logic signed [SUM_W-1:0] sim_s;
   logic signed [SUM_W-1:0] c_diag, c_up, c_left, c_max;

   // previous row read one column ahead through a register; the first row sees zeros
   assign up = ctrl.first_row ? '0 : up_rd_ff;

   always_comb begin
      sim_s  = sym_match ? SUM_W'(MATCH_SCORE) : SUM_W'(MISMATCH_SCORE);
      c_diag = signed'({2'b00, diag_ff}) + sim_s;
      c_up   = signed'({2'b00, up}) - SUM_W'(GAP_PENALTY);
      c_left = signed'({2'b00, left_ff}) - SUM_W'(GAP_PENALTY);
      c_max  = '0;
      if (c_diag > c_max) begin
         c_max = c_diag;
      end
      if (c_up > c_max) begin
         c_max = c_up;
      end
      if (c_left > c_max) begin
         c_max = c_left;
      end
      cell_score = c_max[SCORE_W-1:0];
   end

   always_comb begin
      diag_in = diag_ff;
      left_in = left_ff;
      best_in = best_ff;
      if (ctrl.clear || ctrl.row_start) begin
         diag_in = '0;
         left_in = '0;
      end else if (ctrl.cell_en) begin
         diag_in = up;
         left_in = cell_score;
      end
      if (ctrl.clear) begin
         best_in = '0;
      end else if (ctrl.cell_en && (cell_score > best_ff)) begin
         best_in = cell_score;
      end
   end

   // write column j while reading column j+1: never the same entry
   always_ff @(posedge clock) begin
      if (ctrl.cell_en) begin
         row_mem[ctrl.wr_col] <= cell_score;
      end
      up_rd_ff <= row_mem[ctrl.rd_col];
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      left_ff <= left_in;
      best_ff <= best_in;
   end

   assign best_score = best_ff;

endmodule

FILE: design/local_alignment_score_check_unit.sv
// Local alignment score checker.
// req channel: one transaction per item; req_tuser carries the opcode
// (append to first sequence, append to second, compute), req_tdata the symbol.
// Appends are taken one per cycle while idle and write the symbol stores directly;
// a store that is full drops the symbol and flags it on the next result.
// A compute sweeps the Smith-Waterman matrix row by row, one cell per
// cycle within a row against a row memory, and yields one rsp transaction
// with the best cell score, the pass flag and the drop flag. The sweep is
// bound by the single row memory read/write per cycle. req_tready is low
// for the whole compute.
// A finished result sits in the output register; appends keep flowing while
// it waits, but the next compute holds in its final step until rsp_tready
// frees the register.
// Reset (synchronous) clears lengths, drop flag, threshold and the output
// valid; the symbol and row memories are not cleared.
// csr port: register 0 (byte address 0) is the signed Q4.8 score threshold.
module local_alignment_score_check_unit (
   input  logic                          clock,
   input  logic                          reset,
   // transaction in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] symbol
   input  logic [lasc_pkg::OP_W-1:0]     req_tuser,   // [1:0] opcode
   // transaction out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [9:0] best_score, [10] passed,
                                                      // [11] dropped, [15:12] zero
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lasc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lasc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lasc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import lasc_pkg::*;

   logic [SYM_W-1:0] first_mem  [MAX_LEN];
   logic [SYM_W-1:0] second_mem [MAX_LEN];

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  first_len_ff, first_len_in;
   logic [LEN_W-1:0]  second_len_ff, second_len_in;
   logic              overflow_ff, overflow_in;
   logic [LEN_W-1:0]  row_ff, row_in;
   logic [LEN_W-1:0]  col_ff, col_in;
   logic [THR_W-1:0]  threshold_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic [SYM_W-1:0]  first_rd_ff;
   logic [SYM_W-1:0]  second_rd_ff;

   opcode_type        opcode;
   logic              req_fire;
   logic              first_full, second_full;
   logic              first_wr, second_wr;
   logic [LEN_W-1:0]  col_next;
   logic [IDX_W-1:0]  second_rd_addr;
   logic              load_rsp;
   cell_ctrl_type     ctrl;
   logic [SCORE_W-1:0] best_score;
   logic [LEN_W-1:0]  shorter;
   logic signed [PROD_W-1:0] thr_prod, best_scaled;
   logic              passed;
   logic              csr_write;

   assign opcode      = opcode_type'(req_tuser);
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign first_full  = (first_len_ff == LEN_W'(MAX_LEN));
   assign second_full = (second_len_ff == LEN_W'(MAX_LEN));
   assign first_wr    = req_fire && (opcode == OP_APPEND_FIRST) && !first_full;
   assign second_wr   = req_fire && (opcode == OP_APPEND_SECOND) && !second_full;
   assign col_next    = col_ff + LEN_W'(1);
   assign load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_THRESHOLD) begin
         csr_prdata = CSR_DW'(signed'(threshold_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == REG_THRESHOLD)) begin
         threshold_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      ctrl          = '0;
      ctrl.first_row = (row_ff == '0);
      ctrl.wr_col    = col_ff[IDX_W-1:0];
      ctrl.rd_col    = col_next[IDX_W-1:0];
      second_rd_addr = col_next[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (first_wr) begin
               first_len_in = first_len_ff + LEN_W'(1);
            end
            if (second_wr) begin
               second_len_in = second_len_ff + LEN_W'(1);
            end
            if (req_fire && (opcode == OP_APPEND_FIRST) && first_full) begin
               overflow_in = 1'b1;
            end
            if (req_fire && (opcode == OP_APPEND_SECOND) && second_full) begin
               overflow_in = 1'b1;
            end
            if (req_fire && (opcode == OP_COMPUTE)) begin
               ctrl.clear = 1'b1;
               row_in     = '0;
               if ((first_len_ff != '0) && (second_len_ff != '0)) begin
                  state_in = ST_ROW;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROW: begin
            ctrl.row_start = 1'b1;
            ctrl.rd_col    = '0;
            second_rd_addr = '0;
            col_in         = '0;
            state_in       = ST_CELL;
         end
         ST_CELL: begin
            ctrl.cell_en = 1'b1;
            if (col_next == second_len_ff) begin
               row_in = row_ff + LEN_W'(1);
               if (row_ff + LEN_W'(1) == first_len_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROW;
               end
            end else begin
               col_in = col_next;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               first_len_in  = '0;
               second_len_in = '0;
               overflow_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
   end

   // symbol stores
   always_ff @(posedge clock) begin
      if (first_wr) begin
         first_mem[first_len_ff[IDX_W-1:0]] <= req_tdata[SYM_W-1:0];
      end
      if (state_ff == ST_ROW) begin
         first_rd_ff <= first_mem[row_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (second_wr) begin
         second_mem[second_len_ff[IDX_W-1:0]] <= req_tdata[SYM_W-1:0];
      end
      second_rd_ff <= second_mem[second_rd_addr];
   end

   lasc_cell_core u_cell_core (
      .clock      (clock),
      .ctrl       (ctrl),
      .sym_match  (first_rd_ff == second_rd_ff),
      .best_score (best_score)
   );

   // pass test: best * 256 > threshold * shorter length
   assign shorter     = (first_len_ff < second_len_ff) ? first_len_ff : second_len_ff;
   assign thr_prod    = PROD_W'(signed'(threshold_ff) * signed'({1'b0, shorter}));
   assign best_scaled = signed'({{(PROD_W - SCORE_W - FRAC_W){1'b0}}, best_score,
                                 {FRAC_W{1'b0}}});
   assign passed      = (best_scaled > thr_prod);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, overflow_ff, passed, best_score};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (first_len_ff <= LEN_W'(MAX_LEN)) && (second_len_ff <= LEN_W'(MAX_LEN)))
      else $error("sequence length beyond store depth");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (col_ff < second_len_ff) && (row_ff < first_len_ff))
      else $error("sweep index outside loaded sequences");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (first_len_ff == '0) && (second_len_ff == '0) && !overflow_ff
                   && rsp_tvalid)
      else $error("lengths or drop flag not cleared after result");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |->
         ({1'b0, best_score} <= (LEN_W + 2)'(MATCH_SCORE) * (LEN_W + 2)'(shorter)))
      else $error("best score exceeds match score times shorter length");

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROW) || (state_ff == ST_CELL)) |=>
         $stable(first_len_ff) && $stable(second_len_ff))
      else $error("lengths changed during sweep");
`endif

endmodule
